// ===== rtl/mvsm_pkg.sv =====
// Package: shared types and constants for the sample mixer.
package mvsm_pkg;

  localparam int VOICES           = 32;
  localparam int SAMPLE_ADDR_BITS = 16;
  localparam int VIDX_BITS        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCNT_BITS        = $clog2(VOICES + 1);
  localparam int MEM_DEPTH        = 1 << SAMPLE_ADDR_BITS;
  localparam int OUT_RATE         = 48000;
  // (rate << 16) / OUT_RATE == rate * 512 / 375 == (rate * STEP_RECIP) >> STEP_SHIFT,
  // exact for every 16-bit rate; STEP_RECIP is ceil(2^34 / 375)
  localparam int STEP_RECIP       = 45812985;
  localparam int STEP_SHIFT       = 25;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] entity;
    logic [2:0]  sub_channel;
    logic [15:0] sound_base;
    logic [15:0] sound_length;
    logic [15:0] sample_rate;
    logic [7:0]  volume;
    logic [15:0] load_addr;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_sample;
    logic [5:0]         active_voices;
  } out_item_t;

  typedef struct packed {
    logic        active;
    logic [15:0] base;
    logic [15:0] length;
    logic [31:0] position;
    logic [16:0] step;
    logic [7:0]  gain;
    logic [11:0] entity;
    logic [2:0]  sub;
  } voice_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND,
    ST_STEPDIV,
    ST_WRITE,
    ST_STOP,
    ST_TICK_RD,
    ST_TICK_WAIT,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mvsm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mvsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/mvsm_term.sv =====
// Voice term unit: ((byte-128)*256*gain)/255 truncated toward zero, a registered multiply then a combinational divide.
module mvsm_term (
  input  logic               clk,
  input  logic [7:0]         sample_byte,
  input  logic [7:0]         gain,
  output logic signed [16:0] term
);
  logic signed [8:0]  centered;
  logic signed [17:0] prod_r;
  logic [16:0]        mag_in;
  logic [31:0]        quo_full;
  logic [16:0]        mag;

  assign centered = $signed({1'b0, sample_byte}) - 9'sd128;

  // product of centered and gain; the *256 is folded into the divide below
  always_ff @(posedge clk) begin
    prod_r <= centered * $signed({1'b0, gain});
  end

  // |p|*256/255 = |p| + floor(|p|/255); floor(x/255) = (x*32897) >> 23 for x < 2^16
  assign mag_in   = prod_r[17] ? 17'(-prod_r) : prod_r[16:0];
  assign quo_full = 32'(mag_in) * 32'd32897;
  assign mag      = mag_in + 17'(quo_full[31:23]);
  assign term     = prod_r[17] ? -$signed(mag) : $signed(mag);
endmodule

// ===== rtl/multi_voice_sample_mixer_core.sv =====
// Top level of the multi-voice wavetable sample playback mixer.
// One command item enters on in_*; a tick returns one out_* item with the
// saturated mix and the count of voices still playing. The block walks its
// voice table one voice at a time with a single sequencer. A load writes the
// sample memory as it is accepted; clear and stop walk every voice, start walks
// every voice in its search and then takes one reciprocal multiply for the
// resampling step and the write, and a tick skips each silent voice and waits
// on the sample memory read and the term multiplier for each playing voice.
// A tick whose result finds the previous one still waiting holds in its last
// state until the output register frees. The sample memory is not cleared; a
// sound must be loaded before it is played. The output register lets the next
// item enter while a result waits.
module multi_voice_sample_mixer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mvsm_pkg::out_item_t out_data
);
  localparam int VB = mvsm_pkg::VIDX_BITS;
  localparam int AB = mvsm_pkg::SAMPLE_ADDR_BITS;

  mvsm_pkg::state_t   state_r, state_nxt;
  mvsm_pkg::in_item_t item_r;
  mvsm_pkg::voice_t   voice_r [mvsm_pkg::VOICES];
  logic [VB:0]        vi_r;
  logic [VB-1:0]      sel_r;
  logic               found_r;
  logic               have_free_r;
  logic [16:0]        quo_r;
  logic signed [21:0] mix_r;
  logic [mvsm_pkg::VCNT_BITS-1:0] cnt_r;
  logic               ovalid_r;
  mvsm_pkg::out_item_t odata_r;

  logic [VB-1:0]      vi;
  mvsm_pkg::voice_t   cur;
  logic [7:0]         rbyte;
  logic [AB-1:0]      raddr;
  logic signed [16:0] term;
  logic               mem_we;
  logic [41:0]        step_prod;
  logic               out_free;

  assign vi  = vi_r[VB-1:0];
  assign cur = voice_r[vi];
  assign raddr = AB'(32'(cur.base) + 32'(cur.position[31:16]));
  assign mem_we = (state_r == mvsm_pkg::ST_IDLE) && in_valid && in_ready &&
                  (in_data.cmd == mvsm_pkg::CMD_LOAD);
  assign step_prod = 42'(item_r.sample_rate) * 42'(mvsm_pkg::STEP_RECIP);
  assign out_free  = !ovalid_r || out_ready;

  mvsm_ram #(.WIDTH(8), .DEPTH(mvsm_pkg::MEM_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(in_data.load_addr[AB-1:0]),
    .wdata(in_data.load_byte), .raddr(raddr), .rdata(rbyte)
  );

  mvsm_term u_term (.clk(clk), .sample_byte(rbyte), .gain(cur.gain), .term(term));

  // accept whenever idle; a waiting result is held apart in the output register
  assign in_ready  = (state_r == mvsm_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mvsm_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.cmd)
            mvsm_pkg::CMD_START: state_nxt = mvsm_pkg::ST_FIND;
            mvsm_pkg::CMD_STOP:  state_nxt = mvsm_pkg::ST_STOP;
            mvsm_pkg::CMD_TICK:  state_nxt = mvsm_pkg::ST_TICK_RD;
            mvsm_pkg::CMD_CLEAR: state_nxt = mvsm_pkg::ST_CLEAR;
            default:             state_nxt = mvsm_pkg::ST_IDLE;
          endcase
        end
      end
      mvsm_pkg::ST_CLEAR, mvsm_pkg::ST_STOP: begin
        if (vi_r == (VB+1)'(mvsm_pkg::VOICES - 1)) state_nxt = mvsm_pkg::ST_IDLE;
      end
      mvsm_pkg::ST_FIND: begin
        if (vi_r == (VB+1)'(mvsm_pkg::VOICES - 1)) state_nxt = mvsm_pkg::ST_STEPDIV;
      end
      mvsm_pkg::ST_STEPDIV:   state_nxt = mvsm_pkg::ST_WRITE;
      mvsm_pkg::ST_WRITE:     state_nxt = mvsm_pkg::ST_IDLE;
      mvsm_pkg::ST_TICK_RD: begin
        if (vi_r == (VB+1)'(mvsm_pkg::VOICES)) state_nxt = mvsm_pkg::ST_DONE;
        else if (cur.active && (cur.position[31:16] < cur.length))
          state_nxt = mvsm_pkg::ST_TICK_WAIT;
      end
      mvsm_pkg::ST_TICK_WAIT: state_nxt = mvsm_pkg::ST_TICK_MUL;
      mvsm_pkg::ST_TICK_MUL:  state_nxt = mvsm_pkg::ST_TICK_ACC;
      mvsm_pkg::ST_TICK_ACC:  state_nxt = mvsm_pkg::ST_TICK_RD;
      mvsm_pkg::ST_DONE: begin
        if (out_free) state_nxt = mvsm_pkg::ST_IDLE;
      end
      default:                state_nxt = mvsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mvsm_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      vi_r     <= '0;
      mix_r    <= '0;
      cnt_r    <= '0;
      for (int i = 0; i < mvsm_pkg::VOICES; i++) begin
        voice_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == mvsm_pkg::ST_DONE && out_free) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready)               ovalid_r <= 1'b0;
      case (state_r)
        mvsm_pkg::ST_IDLE: begin
          vi_r        <= '0;
          found_r     <= 1'b0;
          have_free_r <= 1'b0;
          mix_r       <= '0;
          cnt_r       <= '0;
          if (in_valid && in_ready) begin
            item_r <= in_data;
          end
        end
        mvsm_pkg::ST_CLEAR: begin
          voice_r[vi] <= '0;
          vi_r <= vi_r + 1'b1;
        end
        mvsm_pkg::ST_STOP: begin
          if (cur.active && cur.entity == item_r.entity && cur.sub == item_r.sub_channel)
            voice_r[vi].active <= 1'b0;
          vi_r <= vi_r + 1'b1;
        end
        mvsm_pkg::ST_FIND: begin
          // hold the first owner match; otherwise the lowest free voice, else voice 0
          if (!found_r && item_r.sub_channel != 3'd0 && cur.active &&
              cur.entity == item_r.entity && cur.sub == item_r.sub_channel) begin
            found_r <= 1'b1;
            sel_r   <= vi;
          end else if (!found_r && !have_free_r && !cur.active) begin
            have_free_r <= 1'b1;
            sel_r       <= vi;
          end else if (!found_r && !have_free_r && vi_r == '0) begin
            sel_r <= '0;
          end
          vi_r <= vi_r + 1'b1;
        end
        mvsm_pkg::ST_STEPDIV: begin
          // resampling step from one reciprocal multiply by the output rate
          quo_r <= 17'(step_prod >> mvsm_pkg::STEP_SHIFT);
        end
        mvsm_pkg::ST_WRITE: begin
          voice_r[sel_r] <= '{active: 1'b1, base: item_r.sound_base,
                              length: item_r.sound_length, position: 32'd0,
                              step: quo_r, gain: item_r.volume,
                              entity: item_r.entity, sub: item_r.sub_channel};
        end
        mvsm_pkg::ST_TICK_RD: begin
          if (vi_r != (VB+1)'(mvsm_pkg::VOICES)) begin
            if (!cur.active) begin
              vi_r <= vi_r + 1'b1;
            end else if (cur.position[31:16] >= cur.length) begin
              voice_r[vi].active <= 1'b0;
              vi_r <= vi_r + 1'b1;
            end
          end
        end
        mvsm_pkg::ST_TICK_ACC: begin
          mix_r <= mix_r + 22'(term);
          cnt_r <= cnt_r + 1'b1;
          voice_r[vi].position <= cur.position + 32'(cur.step);
          vi_r <= vi_r + 1'b1;
        end
        mvsm_pkg::ST_DONE: begin
          // hold the finished mix until the output register is free
          if (out_free) begin
            odata_r.active_voices <= 6'(cnt_r);
            if (mix_r > 22'sd32767)       odata_r.mix_sample <= 16'sh7fff;
            else if (mix_r < -22'sd32768) odata_r.mix_sample <= 16'sh8000;
            else                          odata_r.mix_sample <= mix_r[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // a result is offered only after a tick walk has finished
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == mvsm_pkg::ST_DONE) else $error("stray result");
  // a waiting result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // the voice count never exceeds the voice table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mvsm_pkg::VCNT_BITS'(mvsm_pkg::VOICES)) else $error("count overflow");
endmodule

// ===== sim/multi_voice_sample_mixer_core_tb.sv =====
// Self-checking testbench for the multi-voice sample mixer core.
`timescale 1ns / 100ps

module multi_voice_sample_mixer_core_tb;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int         FULL_TERM    = 32512;   // (255-128)*256 at full gain
  localparam int         HUSH_LIMIT   = 5000;    // cycles with no handshake
  localparam int         TAIL_CYCLES  = 300;     // longer than one tick pass
  localparam int         RANDOM_ITEMS = 1600;
  localparam int         SOUND_WINDOW = 256;     // bytes loaded before any sound plays
  localparam int         MAX_SOUND    = 40;      // longest random sound

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mvsm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mvsm_pkg::out_item_t out_data;

  multi_voice_sample_mixer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the mixer: sample memory and the voice table.
  logic [7:0]  pcm_mem   [mvsm_pkg::MEM_DEPTH];
  logic        vc_on     [mvsm_pkg::VOICES];
  logic [15:0] vc_base   [mvsm_pkg::VOICES];
  logic [15:0] vc_len    [mvsm_pkg::VOICES];
  logic [31:0] vc_pos    [mvsm_pkg::VOICES];
  logic [16:0] vc_step   [mvsm_pkg::VOICES];
  logic [7:0]  vc_gain   [mvsm_pkg::VOICES];
  logic [11:0] vc_owner  [mvsm_pkg::VOICES];
  logic [2:0]  vc_sub    [mvsm_pkg::VOICES];

  mvsm_pkg::out_item_t pending_mix[$];   // expected tick results, oldest first

  int  mismatches  = 0;
  int  mixes_seen  = 0;
  int  ticks_sent  = 0;
  int  starts_sent = 0;
  int  hush_count  = 0;
  int  burst_left  = 0;
  bit  sender_idle = 1'b0;     // allow gaps between bursts
  bit  stream_done = 1'b0;

  typedef struct {
    mvsm_pkg::in_item_t  item;
    bit                  fixed;
    mvsm_pkg::out_item_t mix;
  } row_t;

  row_t directed[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clear every voice entry; sample memory survives.
  function automatic void drop_all_voices();
    for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
      vc_on[v] = 1'b0; vc_base[v] = '0; vc_len[v] = '0; vc_pos[v] = '0;
      vc_step[v] = '0; vc_gain[v] = '0; vc_owner[v] = '0; vc_sub[v] = '0;
    end
  endfunction

  // Apply one command to the shadow state; a tick yields a mix result.
  function automatic void mix_predict(input mvsm_pkg::in_item_t it, output bit gives,
                                      output mvsm_pkg::out_item_t res);
    int          pick;
    int          acc;
    int          live;
    int          centered;
    logic [15:0] addr;
    gives = 1'b0;
    res   = '0;
    case (it.cmd)
      mvsm_pkg::CMD_LOAD: pcm_mem[it.load_addr] = it.load_byte;
      mvsm_pkg::CMD_START: begin
        pick = -1;
        // reuse the voice that already owns this entity and sub-channel
        if (it.sub_channel != 3'd0)
          for (int v = 0; v < mvsm_pkg::VOICES; v++)
            if (pick < 0 && vc_on[v] && vc_owner[v] == it.entity &&
                vc_sub[v] == it.sub_channel)
              pick = v;
        for (int v = 0; v < mvsm_pkg::VOICES; v++)
          if (pick < 0 && !vc_on[v]) pick = v;
        if (pick < 0) pick = 0;
        vc_base[pick]  = it.sound_base;
        vc_len[pick]   = it.sound_length;
        vc_step[pick]  = 17'(({16'd0, it.sample_rate} << 16) / mvsm_pkg::OUT_RATE);
        vc_gain[pick]  = it.volume;
        vc_pos[pick]   = '0;
        vc_owner[pick] = it.entity;
        vc_sub[pick]   = it.sub_channel;
        vc_on[pick]    = 1'b1;
      end
      mvsm_pkg::CMD_STOP:
        for (int v = 0; v < mvsm_pkg::VOICES; v++)
          if (vc_on[v] && vc_owner[v] == it.entity && vc_sub[v] == it.sub_channel)
            vc_on[v] = 1'b0;
      mvsm_pkg::CMD_CLEAR: drop_all_voices();
      mvsm_pkg::CMD_TICK: begin
        acc  = 0;
        live = 0;
        for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
          if (!vc_on[v]) continue;
          if (32'(vc_pos[v][31:16]) >= 32'(vc_len[v])) begin
            vc_on[v] = 1'b0;
            continue;
          end
          addr     = vc_base[v] + vc_pos[v][31:16];
          centered = int'(pcm_mem[addr]) - 128;
          acc     += (centered * 256 * int'(vc_gain[v])) / 255;
          vc_pos[v] = vc_pos[v] + 32'(vc_step[v]);
          live++;
        end
        if (acc > 32767)  acc = 32767;
        if (acc < -32768) acc = -32768;
        res.mix_sample    = 16'(acc);
        res.active_voices = 6'(live);
        gives = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic mvsm_pkg::in_item_t scramble_item();
    mvsm_pkg::in_item_t it;
    it.cmd          = 3'($urandom);
    it.entity       = 12'($urandom);
    it.sub_channel  = 3'($urandom);
    it.sound_base   = 16'($urandom);
    it.sound_length = 16'($urandom);
    it.sample_rate  = 16'($urandom);
    it.volume       = 8'($urandom);
    it.load_addr    = 16'($urandom);
    it.load_byte    = 8'($urandom);
    return it;
  endfunction

  function automatic mvsm_pkg::in_item_t make_cmd(logic [2:0] c, int ent, int sub,
                                                  int base, int len, int rate, int vol);
    mvsm_pkg::in_item_t it;
    it = scramble_item();
    it.cmd = c; it.entity = 12'(ent); it.sub_channel = 3'(sub);
    it.sound_base = 16'(base); it.sound_length = 16'(len);
    it.sample_rate = 16'(rate); it.volume = 8'(vol);
    return it;
  endfunction

  function automatic mvsm_pkg::in_item_t make_load(int addr, int value);
    mvsm_pkg::in_item_t it;
    it = scramble_item();
    it.cmd = mvsm_pkg::CMD_LOAD; it.load_addr = 16'(addr); it.load_byte = 8'(value);
    return it;
  endfunction

  // Queue one directed row; a typed result marks the row as fixed.
  function automatic void add_row(mvsm_pkg::in_item_t it, bit fixed = 1'b0, int mix = 0,
                                  int live = 0);
    row_t r;
    r.item  = it;
    r.fixed = fixed;
    r.mix.mix_sample    = 16'(mix);
    r.mix.active_voices = 6'(live);
    directed.push_back(r);
  endfunction

  // Drive one item, hold it until accepted, then pace the next one.
  task automatic issue_cmd(input mvsm_pkg::in_item_t it, input bit fixed,
                           input mvsm_pkg::out_item_t typed);
    bit                  gives;
    mvsm_pkg::out_item_t res;
    int                  gap;
    in_valid <= 1'b1;
    in_data  <= it;
    // ready only moves at the rising edge; wait for a falling edge that shows it high
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    mix_predict(it, gives, res);
    if (it.cmd == mvsm_pkg::CMD_TICK)  ticks_sent++;
    if (it.cmd == mvsm_pkg::CMD_START) starts_sent++;
    if (gives) pending_mix.push_back(fixed ? typed : res);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = sender_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Receiver: switch among stall modes, one of which never stalls.
  int stall_mode = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each accepted mix result against the oldest expectation.
  always @(posedge clk) begin
    mvsm_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      mixes_seen++;
      if (pending_mix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected mix result: sample %0d voices %0d",
                   out_data.mix_sample, out_data.active_voices);
      end else begin
        want = pending_mix.pop_front();
        if (out_data.mix_sample !== want.mix_sample ||
            out_data.active_voices !== want.active_voices) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mix mismatch #%0d: expected sample %0d voices %0d, got %0d / %0d",
                     mixes_seen, want.mix_sample, want.active_voices,
                     out_data.mix_sample, out_data.active_voices);
        end
      end
    end
  end

  // Watchdog: too long with neither channel moving ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || stream_done)
      hush_count <= 0;
    else
      hush_count <= hush_count + 1;
    if (hush_count >= HUSH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mvsm_pkg::in_item_t  it;
    mvsm_pkg::out_item_t none;
    int                  r;
    int                  v;
    none     = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    drop_all_voices();
    for (int a = 0; a < mvsm_pkg::MEM_DEPTH; a++) pcm_mem[a] = 8'd0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle mixer: a tick with nothing playing reads no memory.
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    // Fill the sound window so that no voice can read an unwritten byte.
    foreach (directed[i]) issue_cmd(directed[i].item, directed[i].fixed, directed[i].mix);
    directed.delete();
    for (int a = 0; a < SOUND_WINDOW; a++)
      issue_cmd(make_load(a, $urandom_range(0, 255)), 1'b0, none);
    sender_idle = 1'b1;

    // Directed table: extremes of the bytes, voice reuse, wrap and saturation.
    add_row(make_load(0, 255));
    add_row(make_load(1, 0));
    add_row(make_load(16'hFFFF, 128));
    add_row(make_cmd(mvsm_pkg::CMD_START, 12'hFFF, 7, 0, 1, 0, 255));      // zero rate
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, FULL_TERM, 1);
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, FULL_TERM, 1);
    add_row(make_cmd(mvsm_pkg::CMD_START, 12'hFFF, 7, 1, 0, 0, 255));      // reuse, zero length
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    add_row(make_cmd(mvsm_pkg::CMD_START, 5, 0, 16'hFFFF, 2, 48000, 255)); // address wrap
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 1);
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, FULL_TERM, 1);
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    for (int k = 0; k < 3; k++)
      add_row(make_cmd(mvsm_pkg::CMD_START, 1, 0, 0, 65535, 0, 255));
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 32767, 3);
    add_row(make_cmd(mvsm_pkg::CMD_STOP, 1, 0, 0, 0, 0, 0));
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    for (int k = 0; k < 3; k++)
      add_row(make_cmd(mvsm_pkg::CMD_START, 2, 3, 1, 65535, 65535, 255));
    add_row(make_cmd(mvsm_pkg::CMD_START, 9, 1, 0, 4, 65535, 0));          // silent voice
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, -32768, 2);
    add_row(make_cmd(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(mvsm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(mvsm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    foreach (directed[i]) issue_cmd(directed[i].item, directed[i].fixed, directed[i].mix);

    // Random commands, weighted toward ticks and starts of short sounds.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it = scramble_item();
      r  = $urandom_range(0, 99);
      if (r < 40) begin
        it.cmd = mvsm_pkg::CMD_TICK;
      end else if (r < 65) begin
        it.cmd = mvsm_pkg::CMD_START;
        // keep every sound inside the loaded window
        it.sound_length = 16'($urandom_range(0, MAX_SOUND));
        it.sound_base   = 16'($urandom_range(0, SOUND_WINDOW - 1 - MAX_SOUND));
        if ($urandom_range(0, 9) != 0) it.entity = 12'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) it.sample_rate = 16'd0;
      end else if (r < 77) begin
        it.cmd = mvsm_pkg::CMD_STOP;
        v = $urandom_range(0, mvsm_pkg::VOICES - 1);
        if ($urandom_range(0, 3) != 0) begin
          it.entity      = vc_owner[v];
          it.sub_channel = vc_sub[v];
        end
      end else if (r < 94) begin
        it.cmd = mvsm_pkg::CMD_LOAD;
        if ($urandom_range(0, 3) != 0) it.load_addr = 16'($urandom_range(0, SOUND_WINDOW - 1));
      end else if (r < 97) begin
        it.cmd = mvsm_pkg::CMD_CLEAR;
      end else begin
        it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      issue_cmd(it, 1'b0, none);
    end

    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    stream_done = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered: sound window fill, %0d starts, %0d ticks, %0d mix results checked",
             starts_sent, ticks_sent, mixes_seen);
    if (mismatches == 0 && pending_mix.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatch count %0d", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== multi_voice_sample_mixer_core.f =====
rtl/mvsm_pkg.sv
rtl/mvsm_ram.sv
rtl/mvsm_term.sv
rtl/multi_voice_sample_mixer_core.sv
sim/multi_voice_sample_mixer_core_tb.sv
